/* src/kscr_pkg.sv */
// Package: shared types and codes for the kinetic scroll controller.
package kscr_pkg;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] pointer_x;
      logic signed [15:0] pointer_y;
      logic [31:0]        event_time_ms;
   } req_type;

   typedef struct packed {
      logic [15:0] x_position;
      logic [15:0] y_position;
      logic        scrolling;
      logic        animating;
      logic [2:0]  child_action;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   localparam logic [1:0] OP_PUSH    = 2'd0;
   localparam logic [1:0] OP_DRAG    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_TICK    = 2'd3;

   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_PUSH    = 3'd1;
   localparam logic [2:0] ACT_DRAG    = 3'd2;
   localparam logic [2:0] ACT_RELEASE = 3'd3;
   localparam logic [2:0] ACT_CANCEL  = 3'd4;

   localparam logic [2:0] CSR_X_LIMIT   = 3'd0;
   localparam logic [2:0] CSR_Y_LIMIT   = 3'd1;
   localparam logic [2:0] CSR_PRESS_TH  = 3'd2;
   localparam logic [2:0] CSR_TICK_MS   = 3'd3;
   localparam logic [2:0] CSR_DECEL     = 3'd4;
   localparam logic [2:0] CSR_FRICTION  = 3'd5;

   localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;

endpackage

/* src/kscr_div.sv */
// Radix-2 restoring divider, 32 by 32 bits, one quotient bit per cycle.
module kscr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  kscr_pkg::div_req_type div_req,
   output kscr_pkg::div_rsp_type div_rsp
);
   import kscr_pkg::*;

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] rem_shift;
   logic [32:0] trial;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[31]};
      trial     = rem_shift - {1'b0, div_req.divisor};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_shift[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* src/kinetic_scroll_controller.sv */
// Kinetic scroll controller top level: sequencer, state, shared multiplier.
// A scroll drag with nonzero elapsed time computes both velocities in one shared
// divider; an animating tick uses the shared multiplier once per axis. A result waits
// while the result register is stalled. Requests are taken one at a time, the next
// once the previous reached the result register. Synchronous reset initialises the control,
// CSR and scroll registers; request, response and datapath registers are not reset.
module kinetic_scroll_controller #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kscr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kscr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [30:0]       csr_data
);
   import kscr_pkg::*;

   localparam int PW = POSITION_WIDTH;
   localparam int CW = ((PW > 16) ? PW : 16) + 3;
   localparam int VW = (((PW + 25) > 49) ? (PW + 25) : 49) + 1;
   localparam int QW = VW - 24;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EXEC   = 4'd1;
   localparam logic [3:0] S_DSTX   = 4'd2;
   localparam logic [3:0] S_DIVX   = 4'd3;
   localparam logic [3:0] S_DSTY   = 4'd4;
   localparam logic [3:0] S_DIVY   = 4'd5;
   localparam logic [3:0] S_MULX   = 4'd6;
   localparam logic [3:0] S_TICKX  = 4'd7;
   localparam logic [3:0] S_MULY   = 4'd8;
   localparam logic [3:0] S_TICKY  = 4'd9;
   localparam logic [3:0] S_FINISH = 4'd10;

   logic [3:0]  state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  action_ff, action_in;

   logic [15:0] x_limit_ff, x_limit_in, y_limit_ff, y_limit_in;
   logic [7:0]  press_th_ff, press_th_in;
   logic [15:0] tick_ms_ff, tick_ms_in, decel_ff, decel_in;
   logic [30:0] friction_ff, friction_in;

   logic [PW-1:0]      pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [PW-1:0]      start_pos_x_ff, start_pos_x_in, start_pos_y_ff, start_pos_y_in;
   logic signed [15:0] start_ptr_x_ff, start_ptr_x_in, start_ptr_y_ff, start_ptr_y_in;
   logic signed [15:0] prev_ptr_x_ff, prev_ptr_x_in, prev_ptr_y_ff, prev_ptr_y_in;
   logic [31:0]        prev_time_ff, prev_time_in;
   logic signed [31:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic               scroll_ff, scroll_in, anim_ff, anim_in;

   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0]        dt_ff, dt_in;
   logic signed [48:0] prod_ff, prod_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic signed [CW-1:0] pos_max, lim_x, lim_y, nx_raw, ny_raw;
   logic [PW-1:0]        nx, ny;
   logic [15:0]          mag_x, mag_y;
   logic [31:0]          qsat;
   logic signed [31:0]   vel_div;
   logic [31:0]          abs_vx, abs_vy;
   logic signed [31:0]   mul_vel, tick_vel, tick_vel_hit;
   logic [PW-1:0]        tick_pos, tick_pos_new;
   logic signed [CW-1:0] tick_lim;
   logic signed [VW-1:0] tick_v, tick_mag;
   logic [QW-1:0]        tick_q;
   logic                 neg_hit, hi_hit;
   logic signed [31:0]   tick_vel_new;
   logic [CW-1:0]        pos_x_ext, pos_y_ext;

   function automatic logic [PW-1:0] clamp_fn(logic signed [CW-1:0] v,
                                              logic signed [CW-1:0] lim);
      logic [PW-1:0] r;
      if (v < 0) r = '0;
      else if (v > lim) r = lim[PW-1:0];
      else r = v[PW-1:0];
      return r;
   endfunction

   function automatic logic beyond_fn(logic [PW-1:0] a, logic [PW-1:0] b,
                                      logic [7:0] th);
      logic signed [CW-1:0] d;
      logic signed [CW-1:0] t;
      d = $signed(CW'(a)) - $signed(CW'(b));
      t = $signed(CW'(th));
      return (d > t) || (d < -t);
   endfunction

   function automatic logic signed [31:0] slow_fn(logic signed [31:0] v,
                                                  logic [15:0] d);
      logic signed [32:0] t;
      logic signed [31:0] r;
      r = v;
      if (v > 0) begin
         t = 33'(v) - $signed({17'd0, d});
         r = (t < 0) ? 32'sd0 : t[31:0];
      end else if (v < 0) begin
         t = 33'(v) + $signed({17'd0, d});
         r = (t > 0) ? 32'sd0 : t[31:0];
      end
      return r;
   endfunction

   kscr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      pos_max = $signed({{(CW - PW){1'b0}}, {PW{1'b1}}});
      lim_x   = ($signed(CW'(x_limit_ff)) > pos_max) ? pos_max : $signed(CW'(x_limit_ff));
      lim_y   = ($signed(CW'(y_limit_ff)) > pos_max) ? pos_max : $signed(CW'(y_limit_ff));
      nx_raw  = $signed(CW'(start_pos_x_ff)) + CW'(start_ptr_x_ff) - CW'(req_ff.pointer_x);
      ny_raw  = $signed(CW'(start_pos_y_ff)) + CW'(start_ptr_y_ff) - CW'(req_ff.pointer_y);
      nx      = clamp_fn(nx_raw, lim_x);
      ny      = clamp_fn(ny_raw, lim_y);

      mag_x = dx_ff[16] ? 16'(-dx_ff) : dx_ff[15:0];
      mag_y = dy_ff[16] ? 16'(-dy_ff) : dy_ff[15:0];
      div_req.start    = (state_ff == S_DSTX) || (state_ff == S_DSTY);
      div_req.dividend = (state_ff == S_DSTX) ? {mag_x, 16'd0} : {mag_y, 16'd0};
      div_req.divisor  = dt_ff;
      qsat    = (div_rsp.quotient > VEL_MAX) ? VEL_MAX : div_rsp.quotient;
      vel_div = ((state_ff == S_DIVX) ? dx_ff[16] : dy_ff[16]) ?
                -$signed(qsat) : $signed(qsat);

      abs_vx = vel_x_ff[31] ? 32'(-vel_x_ff) : 32'(vel_x_ff);
      abs_vy = vel_y_ff[31] ? 32'(-vel_y_ff) : 32'(vel_y_ff);

      mul_vel = (state_ff == S_MULX) ? vel_x_ff : vel_y_ff;
      prod_in = $signed({33'd0, tick_ms_ff}) * 49'(mul_vel);

      tick_pos = (state_ff == S_TICKX) ? pos_x_ff : pos_y_ff;
      tick_vel = (state_ff == S_TICKX) ? vel_x_ff : vel_y_ff;
      tick_lim = (state_ff == S_TICKX) ? lim_x : lim_y;
      tick_v   = $signed(VW'(tick_pos) << 24) - VW'(prod_ff);
      tick_mag = tick_v[VW-1] ? -tick_v : tick_v;
      tick_q   = tick_mag[VW-1:24];
      neg_hit  = tick_v[VW-1] && (tick_q != '0);
      hi_hit   = !tick_v[VW-1] && (tick_q > QW'(tick_lim[PW-1:0]));
      tick_pos_new = neg_hit ? '0 : (hi_hit ? tick_lim[PW-1:0] : tick_q[PW-1:0]);
      tick_vel_hit = (neg_hit || hi_hit) ? 32'sd0 : tick_vel;
      tick_vel_new = slow_fn(tick_vel_hit, decel_ff);

      pos_x_ext = CW'(pos_x_ff);
      pos_y_ext = CW'(pos_y_ff);
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      action_in      = action_ff;
      x_limit_in     = x_limit_ff;
      y_limit_in     = y_limit_ff;
      press_th_in    = press_th_ff;
      tick_ms_in     = tick_ms_ff;
      decel_in       = decel_ff;
      friction_in    = friction_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      start_pos_x_in = start_pos_x_ff;
      start_pos_y_in = start_pos_y_ff;
      start_ptr_x_in = start_ptr_x_ff;
      start_ptr_y_in = start_ptr_y_ff;
      prev_ptr_x_in  = prev_ptr_x_ff;
      prev_ptr_y_in  = prev_ptr_y_ff;
      prev_time_in   = prev_time_ff;
      vel_x_in       = vel_x_ff;
      vel_y_in       = vel_y_ff;
      scroll_in      = scroll_ff;
      anim_in        = anim_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      dt_in          = dt_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_X_LIMIT:  x_limit_in  = csr_data[15:0];
            CSR_Y_LIMIT:  y_limit_in  = csr_data[15:0];
            CSR_PRESS_TH: press_th_in = csr_data[7:0];
            CSR_TICK_MS:  tick_ms_in  = csr_data[15:0];
            CSR_DECEL:    decel_in    = csr_data[15:0];
            CSR_FRICTION: friction_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            action_in = ACT_NONE;
            state_in  = S_FINISH;
            unique case (req_ff.op)
               OP_PUSH: begin
                  anim_in        = 1'b0;
                  start_pos_x_in = pos_x_ff;
                  start_pos_y_in = pos_y_ff;
                  start_ptr_x_in = req_ff.pointer_x;
                  start_ptr_y_in = req_ff.pointer_y;
                  prev_ptr_x_in  = req_ff.pointer_x;
                  prev_ptr_y_in  = req_ff.pointer_y;
                  prev_time_in   = req_ff.event_time_ms;
                  vel_x_in       = '0;
                  vel_y_in       = '0;
                  if (!scroll_ff) action_in = ACT_PUSH;
                  scroll_in      = 1'b0;
               end
               OP_DRAG: begin
                  if (!scroll_ff && !(beyond_fn(start_pos_y_ff, ny, press_th_ff) ||
                                      beyond_fn(start_pos_x_ff, nx, press_th_ff))) begin
                     action_in = ACT_DRAG;
                  end else begin
                     if (!scroll_ff) begin
                        action_in = ACT_CANCEL;
                        scroll_in = 1'b1;
                     end
                     dx_in         = 17'(req_ff.pointer_x) - 17'(prev_ptr_x_ff);
                     dy_in         = 17'(req_ff.pointer_y) - 17'(prev_ptr_y_ff);
                     dt_in         = req_ff.event_time_ms - prev_time_ff;
                     prev_ptr_x_in = req_ff.pointer_x;
                     prev_ptr_y_in = req_ff.pointer_y;
                     prev_time_in  = req_ff.event_time_ms;
                     pos_x_in      = nx;
                     pos_y_in      = ny;
                     if (req_ff.event_time_ms != prev_time_ff) state_in = S_DSTX;
                  end
               end
               OP_RELEASE: begin
                  if (!scroll_ff) action_in = ACT_RELEASE;
                  if ((abs_vx > {1'b0, friction_ff}) || (abs_vy > {1'b0, friction_ff}))
                     anim_in = 1'b1;
                  else
                     scroll_in = 1'b0;
               end
               OP_TICK: begin
                  if (anim_ff) state_in = S_MULX;
               end
               default: ;
            endcase
         end
         S_DSTX: state_in = S_DIVX;
         S_DIVX: begin
            if (div_rsp.done) begin
               vel_x_in = vel_div;
               state_in = S_DSTY;
            end
         end
         S_DSTY: state_in = S_DIVY;
         S_DIVY: begin
            if (div_rsp.done) begin
               vel_y_in = vel_div;
               state_in = S_FINISH;
            end
         end
         S_MULX: state_in = S_TICKX;
         S_TICKX: begin
            pos_x_in = tick_pos_new;
            vel_x_in = tick_vel_new;
            state_in = S_MULY;
         end
         S_MULY: state_in = S_TICKY;
         S_TICKY: begin
            pos_y_in = tick_pos_new;
            vel_y_in = tick_vel_new;
            if ((vel_x_ff == 0) && (tick_vel_new == 0)) begin
               scroll_in = 1'b0;
               anim_in   = 1'b0;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_in.x_position   = pos_x_ext[15:0];
               rsp_in.y_position   = pos_y_ext[15:0];
               rsp_in.scrolling    = scroll_ff;
               rsp_in.animating    = anim_ff;
               rsp_in.child_action = action_ff;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dt_ff   <= dt_in;
      prod_ff <= prod_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         action_ff      <= ACT_NONE;
         x_limit_ff     <= '0;
         y_limit_ff     <= '0;
         press_th_ff    <= 8'd10;
         tick_ms_ff     <= 16'd4267;
         decel_ff       <= 16'd5461;
         friction_ff    <= 31'd16384;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         start_pos_x_ff <= '0;
         start_pos_y_ff <= '0;
         start_ptr_x_ff <= '0;
         start_ptr_y_ff <= '0;
         prev_ptr_x_ff  <= '0;
         prev_ptr_y_ff  <= '0;
         prev_time_ff   <= '0;
         vel_x_ff       <= '0;
         vel_y_ff       <= '0;
         scroll_ff      <= 1'b0;
         anim_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         action_ff      <= action_in;
         x_limit_ff     <= x_limit_in;
         y_limit_ff     <= y_limit_in;
         press_th_ff    <= press_th_in;
         tick_ms_ff     <= tick_ms_in;
         decel_ff       <= decel_in;
         friction_ff    <= friction_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         start_pos_x_ff <= start_pos_x_in;
         start_pos_y_ff <= start_pos_y_in;
         start_ptr_x_ff <= start_ptr_x_in;
         start_ptr_y_ff <= start_ptr_y_in;
         prev_ptr_x_ff  <= prev_ptr_x_in;
         prev_ptr_y_ff  <= prev_ptr_y_in;
         prev_time_ff   <= prev_time_in;
         vel_x_ff       <= vel_x_in;
         vel_y_ff       <= vel_y_in;
         scroll_ff      <= scroll_in;
         anim_ff        <= anim_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
